// File: hdl/ryuv_pkg.sv
// ryuv_pkg: shared types, register codes and Q16 color-space constants
// for the RGB to YUV 4:2:0 converter. No dependencies.
`default_nettype none

package ryuv_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 8'd0,
    REG_FRAME_HEIGHT = 8'd1
  } cfg_reg_t;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 360;

  // Index counters
  localparam int LIDX_W = 24;
  localparam int CIDX_W = 22;

  // Q16 sums fit in 26 signed bits for 8-bit inputs
  localparam int SUM_W = 26;

  localparam logic signed [SUM_W-1:0] CY_R   =  26'sd19595;
  localparam logic signed [SUM_W-1:0] CY_G   =  26'sd38470;
  localparam logic signed [SUM_W-1:0] CY_B   =  26'sd7471;
  localparam logic signed [SUM_W-1:0] CU_R   = -26'sd11076;
  localparam logic signed [SUM_W-1:0] CU_G   = -26'sd21692;
  localparam logic signed [SUM_W-1:0] CU_B   =  26'sd32768;
  localparam logic signed [SUM_W-1:0] CV_R   =  26'sd32768;
  localparam logic signed [SUM_W-1:0] CV_G   = -26'sd27460;
  localparam logic signed [SUM_W-1:0] CV_B   = -26'sd5308;
  localparam logic signed [SUM_W-1:0] C_OFS  =  26'sd8388608;  // 128 << 16

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_pix_t;

  typedef struct packed {
    logic [7:0] chroma_v;
    logic [7:0] chroma_u;
    logic [7:0] luma;
  } yuv_t;

  // Negative -> 0, else truncate by 16 and limit to 255
  function automatic logic [7:0] q16_to_byte(input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-17:0] whole;
    begin
      whole = sum[SUM_W-1:16];
      if (sum < 0) begin
        q16_to_byte = 8'd0;
      end else if (whole > (SUM_W-16)'(255)) begin
        q16_to_byte = 8'd255;
      end else begin
        q16_to_byte = whole[7:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/ryuv_csc.sv
// ryuv_csc: BT.601 color-space matrix in Q16 with clamp to 8 bits.
// Depends on ryuv_pkg (coefficients, pixel types, q16_to_byte).
`default_nettype none

module ryuv_csc
  import ryuv_pkg::*;
(
  input  rgb_pix_t pix,
  input  logic     keep,   // chroma kept for this pixel
  output yuv_t     yuv
);

  logic signed [SUM_W-1:0] r_s, g_s, b_s;
  logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;

  assign r_s = $signed({{(SUM_W-8){1'b0}}, pix.red});
  assign g_s = $signed({{(SUM_W-8){1'b0}}, pix.green});
  assign b_s = $signed({{(SUM_W-8){1'b0}}, pix.blue});

  assign y_sum = CY_R * r_s + CY_G * g_s + CY_B * b_s;
  assign u_sum = CU_R * r_s + CU_G * g_s + CU_B * b_s + C_OFS;
  assign v_sum = CV_R * r_s + CV_G * g_s + CV_B * b_s + C_OFS;

  always_comb begin
    yuv.luma     = q16_to_byte(y_sum);
    yuv.chroma_u = keep ? q16_to_byte(u_sum) : 8'd0;
    yuv.chroma_v = keep ? q16_to_byte(v_sum) : 8'd0;
  end

endmodule

`default_nettype wire

// File: hdl/rgb_to_yuv420_converter_top.sv
// rgb_to_yuv420_converter_top: raster RGB pixel in, YUV 4:2:0 word out.
// Depends on ryuv_pkg and ryuv_csc.
//
// Usage:
//  - in_*  : one RGB pixel per word, raster order (tdata = red, green, blue).
//  - out_* : one result word per pixel. tdata carries luma, U, V, the luma
//    plane index and the chroma index; tuser is chroma_valid (even column
//    of an even row); tlast flags the last pixel of the frame.
//  - cfg_* : frame width (index 0) and height (index 1); always ready.
//    Zero reads as 1, values above MAX_WIDTH / MAX_HEIGHT saturate.
//    Write only while no pixel is in flight.
// Path: the input register, then the combinational Q16 matrix into the output
// register, which drives out_*.
// Throughput: one pixel per cycle while out_tready is high; a new pixel is
// taken while a finished word waits on out_tready if the input stage is empty.
// Stall: when out_tready is low the output word holds, the input stage
// fills, and in_tready drops only once both stages hold a word.
// Reset: counters clear, size registers return to 640 x 360, both stages
// go empty.
`default_nettype none

module rgb_to_yuv420_converter_top
  import ryuv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,    // red[7:0], green[15:8], blue[23:16]

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // luma[7:0], chroma_u[15:8], chroma_v[23:16], luma_index[47:24],
  // chroma_index[69:48], zero pad[71:70]
  output logic [71:0]           out_tdata,
  output logic                  out_tuser,   // chroma_valid
  output logic                  out_tlast,   // frame_end

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [CW-1:0] WLAST_MAX = CW'(MAX_WIDTH - 1);
  localparam logic [RW-1:0] HLAST_MAX = RW'(MAX_HEIGHT - 1);
  localparam logic [CW-1:0] WLAST_RST =
    CW'(((WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST) - 1);
  localparam logic [RW-1:0] HLAST_RST =
    RW'(((HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST) - 1);

  // Size registers hold the last column / row index (effective size - 1)
  logic [CW-1:0] wlast_r, wlast_nxt;
  logic [RW-1:0] hlast_r, hlast_nxt;

  // Position counters
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [LIDX_W-1:0] pix_cnt_r, pix_cnt_nxt;
  logic [CIDX_W-1:0] chr_cnt_r, chr_cnt_nxt;

  // Input stage
  logic              s1_valid_r, s1_valid_nxt;
  rgb_pix_t          s1_pix_r;
  logic              s1_keep_r;
  logic [LIDX_W-1:0] s1_lidx_r;
  logic [CIDX_W-1:0] s1_cidx_r;
  logic              s1_last_r;

  // Output stage
  logic              s2_valid_r, s2_valid_nxt;
  yuv_t              s2_yuv_r;
  logic              s2_keep_r;
  logic [LIDX_W-1:0] s2_lidx_r;
  logic [CIDX_W-1:0] s2_cidx_r;
  logic              s2_last_r;

  logic in_accept, s2_adv;
  logic keep, row_end, last;
  yuv_t csc_yuv;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_comb begin
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (cfg_data == '0) begin
            wlast_nxt = '0;
          end else if (32'(cfg_data) > MAX_WIDTH) begin
            wlast_nxt = WLAST_MAX;
          end else begin
            wlast_nxt = CW'(cfg_data - CFG_DATA_W'(1));
          end
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_data == '0) begin
            hlast_nxt = '0;
          end else if (32'(cfg_data) > MAX_HEIGHT) begin
            hlast_nxt = HLAST_MAX;
          end else begin
            hlast_nxt = RW'(cfg_data - CFG_DATA_W'(1));
          end
        end
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign s2_adv    = !s2_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_adv;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
    s2_valid_nxt = s2_valid_r;
    if (s2_adv) begin
      s2_valid_nxt = s1_valid_r;
    end
  end

  // ---------------- raster position ----------------
  assign keep    = !col_r[0] && !row_r[0];
  assign row_end = col_r >= wlast_r;
  assign last    = row_end && (row_r >= hlast_r);

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    pix_cnt_nxt = pix_cnt_r;
    chr_cnt_nxt = chr_cnt_r;
    if (in_accept) begin
      pix_cnt_nxt = pix_cnt_r + LIDX_W'(1);
      if (keep) begin
        chr_cnt_nxt = chr_cnt_r + CIDX_W'(1);
      end
      if (row_end) begin
        col_nxt = '0;
        if (last) begin
          row_nxt     = '0;
          pix_cnt_nxt = '0;
          chr_cnt_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r    <= WLAST_RST;
      hlast_r    <= HLAST_RST;
      col_r      <= '0;
      row_r      <= '0;
      pix_cnt_r  <= '0;
      chr_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      wlast_r    <= wlast_nxt;
      hlast_r    <= hlast_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pix_cnt_r  <= pix_cnt_nxt;
      chr_cnt_r  <= chr_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Input stage payload: pixel plus its position info
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r  <= rgb_pix_t'(in_tdata);
      s1_keep_r <= keep;
      s1_lidx_r <= pix_cnt_r;
      s1_cidx_r <= keep ? chr_cnt_r : '0;
      s1_last_r <= last;
    end
  end

  // ---------------- color conversion ----------------
  ryuv_csc u_csc (
    .pix  (s1_pix_r),
    .keep (s1_keep_r),
    .yuv  (csc_yuv)
  );

  // Output stage payload
  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      s2_yuv_r  <= csc_yuv;
      s2_keep_r <= s1_keep_r;
      s2_lidx_r <= s1_lidx_r;
      s2_cidx_r <= s1_cidx_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {2'b00, s2_cidx_r, s2_lidx_r,
                       s2_yuv_r.chroma_v, s2_yuv_r.chroma_u, s2_yuv_r.luma};
  assign out_tuser  = s2_keep_r;
  assign out_tlast  = s2_last_r;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// tb_top: self-checking bench for rgb_to_yuv420_converter_top. It drives RGB pixel
// words and register writes, predicts every YUV word and checks it at the output.
// Depends on ryuv_pkg and the converter RTL.
`timescale 1ns / 100ps

module tb_top
  import ryuv_pkg::*;
();

  // Q16 color matrix, round(c * 65536)
  localparam int K_YR = 19595;
  localparam int K_YG = 38470;
  localparam int K_YB = 7471;
  localparam int K_UR = -11076;
  localparam int K_UG = -21692;
  localparam int K_UB = 32768;
  localparam int K_VR = 32768;
  localparam int K_VG = -27460;
  localparam int K_VB = -5308;
  localparam int CHROMA_OFS = 128 << 16;

  localparam int MAX_SIDE = 4096;
  localparam int WIDTH_AT_RESET  = 640;
  localparam int HEIGHT_AT_RESET = 360;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 8'hFF;

  localparam int MAX_GAP        = 17;
  localparam int RX_HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RAND_ITEMS     = 60;
  localparam int MAX_PRINTED    = 40;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  typedef struct {
    logic [7:0]  luma;
    logic [7:0]  cu;
    logic [7:0]  cv;
    logic        cvalid;
    logic [23:0] lidx;
    logic [21:0] cidx;
    logic        fend;
  } yuv_word_t;

  // Tracks raster position and holds the YUV words still owed by the block
  class yuv_tracker;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [11:0] col;
    logic [11:0] row;
    logic [23:0] pix_cnt;
    logic [21:0] chr_cnt;
    yuv_word_t   owed_words[$];
    int          errors;

    function void reset_state();
      width_reg  = 13'(WIDTH_AT_RESET);
      height_reg = 13'(HEIGHT_AT_RESET);
      col = '0;
      row = '0;
      pix_cnt = '0;
      chr_cnt = '0;
      owed_words.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = val;
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = val;
      end
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    function int eff_size(logic [12:0] regv);
      if (regv == 0) return 1;
      return (int'(regv) > MAX_SIDE) ? MAX_SIDE : int'(regv);
    endfunction

    // negative -> 0, else integer part limited to 255
    function logic [7:0] q16_byte(int s);
      if (s < 0) return 8'd0;
      if ((s >>> 16) > 255) return 8'hFF;
      return 8'(s >>> 16);
    endfunction

    function void note_pixel(rgb_pix_t px);
      int r, g, b, w, h, ys, us, vs;
      bit keep, row_end, last;
      yuv_word_t e;
      r = px.red;
      g = px.green;
      b = px.blue;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      keep = !col[0] && !row[0];
      // counters left beyond a shrunken frame end their row/frame right away
      row_end = (int'(col) + 1 >= w);
      last = row_end && (int'(row) + 1 >= h);
      ys = K_YR * r + K_YG * g + K_YB * b;
      us = K_UR * r + K_UG * g + K_UB * b + CHROMA_OFS;
      vs = K_VR * r + K_VG * g + K_VB * b + CHROMA_OFS;
      e.luma   = q16_byte(ys);
      e.cu     = keep ? q16_byte(us) : 8'd0;
      e.cv     = keep ? q16_byte(vs) : 8'd0;
      e.cvalid = keep;
      e.lidx   = pix_cnt;
      e.cidx   = keep ? chr_cnt : '0;
      e.fend   = last;
      owed_words.push_back(e);
      if (keep) chr_cnt++;
      pix_cnt++;
      if (row_end) begin
        col = '0;
        if (last) begin
          row = '0;
          pix_cnt = '0;
          chr_cnt = '0;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task cmp(string name, logic [23:0] got, logic [23:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_word(yuv_word_t got);
      yuv_word_t want;
      if (owed_words.size() == 0) begin
        report("output word with nothing outstanding");
        return;
      end
      want = owed_words.pop_front();
      cmp("luma", 24'(got.luma), 24'(want.luma));
      cmp("chroma_u", 24'(got.cu), 24'(want.cu));
      cmp("chroma_v", 24'(got.cv), 24'(want.cv));
      cmp("chroma_valid", 24'(got.cvalid), 24'(want.cvalid));
      cmp("luma_index", got.lidx, want.lidx);
      cmp("chroma_index", 24'(got.cidx), 24'(want.cidx));
      cmp("frame_end", 24'(got.fend), 24'(want.fend));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [71:0]           out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  yuv_tracker sb = new();
  bit         tx_idle_on;
  bit         rx_idle_on;
  bit         rx_hold_req;
  yuv_word_t  seen;

  rgb_to_yuv420_converter_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Output words are taken on the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      seen.luma   = out_tdata[7:0];
      seen.cu     = out_tdata[15:8];
      seen.cv     = out_tdata[23:16];
      seen.lidx   = out_tdata[47:24];
      seen.cidx   = out_tdata[69:48];
      seen.cvalid = out_tuser;
      seen.fend   = out_tlast;
      sb.check_word(seen);
    end
  end

  // Receiver: random back-pressure per word, plus a long hold-off on request
  initial begin : rx_side
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_tready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
    end
  end

  initial begin : watchdog
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  function automatic rgb_pix_t rand_pixel();
    rgb_pix_t px;
    px = rgb_pix_t'($urandom);
    // now and then pin channels to the rails
    if ($urandom_range(0, 7) == 0) begin
      px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return px;
  endfunction

  // Called at a falling edge; returns at the falling edge after the accept
  task automatic send_pixel(input rgb_pix_t px);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = px;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Registers change only with no pixel in flight
  task automatic write_reg_idle(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One frame geometry, n random pixels. hold: receiver stalls long while
  // the sender runs flat out. pause: sender waits for a full drain midway.
  task automatic run_frame_phase(input int w, input int h, input int n,
                                 input bit idle, input bit hold, input bit pause);
    int k;
    if ($urandom_range(0, 1)) begin
      write_reg_idle(REG_FRAME_WIDTH, 13'(w));
      write_reg_idle(REG_FRAME_HEIGHT, 13'(h));
    end else begin
      write_reg_idle(REG_FRAME_HEIGHT, 13'(h));
      write_reg_idle(REG_FRAME_WIDTH, 13'(w));
    end
    tx_idle_on = idle && !hold && ($urandom_range(0, 3) != 0);
    rx_idle_on = idle && ($urandom_range(0, 3) != 0);
    if (hold) rx_hold_req = 1'b1;
    for (k = 0; k < n; k++) begin
      if (pause && k == n / 2) wait_drained();
      send_pixel(rand_pixel());
    end
  endtask

  initial begin : main
    int k, w, h, n, rand_items;
    rgb_pix_t px;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_FRAME_WIDTH;
    cfg_data    = '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    rx_hold_req = 1'b0;
    sb.reset_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pixels at the reset frame size: rail corners, walking ones,
    // walking zeros
    for (k = 0; k < 8; k++) begin
      px.red   = k[0] ? 8'hFF : 8'h00;
      px.green = k[1] ? 8'hFF : 8'h00;
      px.blue  = k[2] ? 8'hFF : 8'h00;
      send_pixel(px);
    end
    for (k = 0; k < 8; k++) begin
      px.red   = 8'(1 << k);
      px.green = 8'(1 << k);
      px.blue  = 8'(1 << k);
      send_pixel(px);
    end
    for (k = 0; k < 8; k++) begin
      px.red   = ~8'(1 << k);
      px.green = ~8'(1 << k);
      px.blue  = ~8'(1 << k);
      send_pixel(px);
    end

    // Zero size reads as 1: every pixel closes a frame
    run_frame_phase(0, 0, 20, 1, 0, 0);
    run_frame_phase(1, 5, 30, 1, 0, 0);
    run_frame_phase(2, 2, 40, 1, 0, 0);
    run_frame_phase(3, 3, 60, 1, 0, 0);
    // Block fills and stalls its input while the receiver holds off
    run_frame_phase(5, 4, 80, 1, 1, 0);
    run_frame_phase(7, 1, 40, 1, 0, 0);
    // Writes to an index with no register are ignored
    write_reg_idle(CFG_IDX_SPARE_LO, 13'h1FFF);
    write_reg_idle(CFG_IDX_SPARE_HI, 13'h0001);
    run_frame_phase(16, 9, 150, 1, 0, 1);
    // Oversized registers saturate at the maximum frame side
    run_frame_phase(8191, 1, 40, 0, 0, 0);
    run_frame_phase(1, 4097, 40, 0, 0, 0);
    run_frame_phase(4096, 4096, 100, 1, 0, 0);
    // Shrink mid-frame: column already past the new width
    run_frame_phase(6, 3, 30, 1, 0, 0);
    // Raise the height, then shrink it mid-frame: row already past the new height
    run_frame_phase(1, 50, 20, 1, 0, 0);
    run_frame_phase(1, 5, 12, 1, 0, 0);
    run_frame_phase(4097, 2, 50, 1, 0, 0);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 24);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 12);
      n = $urandom_range(20, 120);
      if ($urandom_range(0, 4) == 0)
        write_reg_idle(8'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                       13'($urandom));
      run_frame_phase(w, h, n, 1, $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
      rand_items += n;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
